/* design/sbin_pkg.sv */
`timescale 1ns / 1ps

package sbin_pkg;

    // Width used for all raster limit arithmetic; holds any limit up to 4096 plus one.
    localparam int CNT_W = 13;

    // Pixel rows per frame are fixed at 1024 at most.
    localparam int ROW_W        = 10;
    localparam int HEIGHT_LIMIT = 1024;

    localparam int DATA_W = 32;

    // Output queue depth: enough for a request in flight and one in the compute stage.
    localparam int FIFO_DEPTH = 4;

    localparam logic [3:0]        BIN_RESET    = 4'd2;
    localparam logic [10:0]       WIDTH_RESET  = 11'd1024;
    localparam logic [10:0]       HEIGHT_RESET = 11'd1024;
    localparam logic [DATA_W-1:0] MAX_RESET    = 32'd65535;

    typedef enum logic [1:0] {
        CFG_BIN_FACTOR   = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2,
        CFG_MAX_ADU      = 2'd3
    } cfg_idx_t;

    // Position flags of one accepted sub-pixel.
    typedef struct packed {
        logic start;      // frame_start was set on this request
        logic first;      // first sub-pixel of a bin: partial sum starts from zero
        logic emit;       // last sub-pixel of a bin: a pixel is produced
        logic last_col;   // last output column of the row
        logic last_frame; // last output pixel of the frame
        logic frame_end;  // last sub-pixel of the frame
    } raster_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              last_row;
        logic              last_frame;
        logic              frame_sat;
    } out_item_t;

endpackage

/* design/sbin_ram.sv */
`timescale 1ns / 1ps

module sbin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/sbin_raster.sv */
`timescale 1ns / 1ps

module sbin_raster #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BIN   = 8
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            accept,
    input  logic                                            frame_start,
    input  logic [sbin_pkg::CNT_W-1:0]                      bin_lim,
    input  logic [sbin_pkg::CNT_W-1:0]                      width_lim,
    input  logic [sbin_pkg::CNT_W-1:0]                      height_lim,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] col,
    output sbin_pkg::raster_t                               flags
);

    import sbin_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SC_W  = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;

    logic [SC_W-1:0]  sc_reg, sc_next, sc_cur;
    logic [SC_W-1:0]  sr_reg, sr_next, sr_cur;
    logic [COL_W-1:0] pc_reg, pc_next, pc_cur;
    logic [ROW_W-1:0] pr_reg, pr_next, pr_cur;
    logic             last_sc, last_sr, last_pc, last_pr;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            sc_reg <= '0;
            sr_reg <= '0;
            pc_reg <= '0;
            pr_reg <= '0;
        end else begin
            sc_reg <= sc_next;
            sr_reg <= sr_next;
            pc_reg <= pc_next;
            pr_reg <= pr_next;
        end
    end

    always_comb begin
        // A frame start resets the position before this sub-pixel is placed.
        sc_cur = frame_start ? '0 : sc_reg;
        sr_cur = frame_start ? '0 : sr_reg;
        pc_cur = frame_start ? '0 : pc_reg;
        pr_cur = frame_start ? '0 : pr_reg;

        last_sc = (CNT_W'(sc_cur) + CNT_W'(1)) >= bin_lim;
        last_sr = (CNT_W'(sr_cur) + CNT_W'(1)) >= bin_lim;
        last_pc = (CNT_W'(pc_cur) + CNT_W'(1)) >= width_lim;
        last_pr = (CNT_W'(pr_cur) + CNT_W'(1)) >= height_lim;

        sc_next = sc_reg;
        sr_next = sr_reg;
        pc_next = pc_reg;
        pr_next = pr_reg;

        if (accept) begin
            sc_next = sc_cur;
            sr_next = sr_cur;
            pc_next = pc_cur;
            pr_next = pr_cur;
            if (!last_sc) begin
                sc_next = sc_cur + SC_W'(1);
            end else begin
                sc_next = '0;
                if (!last_pc) begin
                    pc_next = pc_cur + COL_W'(1);
                end else begin
                    pc_next = '0;
                    if (!last_sr) begin
                        sr_next = sr_cur + SC_W'(1);
                    end else begin
                        sr_next = '0;
                        if (!last_pr) begin
                            pr_next = pr_cur + ROW_W'(1);
                        end else begin
                            pr_next = '0;
                        end
                    end
                end
            end
        end

        col              = pc_cur;
        flags.start      = frame_start;
        flags.first      = (sc_cur == '0) && (sr_cur == '0);
        flags.emit       = last_sc && last_sr;
        flags.last_col   = last_pc;
        flags.last_frame = last_pc && last_pr;
        flags.frame_end  = last_sc && last_sr && last_pc && last_pr;
    end

endmodule

/* design/sbin_out_fifo.sv */
`timescale 1ns / 1ps

module sbin_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  sbin_pkg::out_item_t                   push_data,
    input  logic                                  pop_ready,
    output logic                                  out_valid,
    output sbin_pkg::out_item_t                   out_data,
    output logic [$clog2(DEPTH + 1)-1:0]          level
);

    import sbin_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    out_item_t        entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             pop;

    always_ff @(posedge clk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_comb begin
        pop         = out_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            level_next = level_reg + LVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    assign out_valid = (level_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    assign level     = level_reg;

endmodule

/* design/subpixel_binning_saturating_core.sv */
`timescale 1ns / 1ps
// A pixel passes the accumulate stage register and then the output queue before reaching the master side.
// Throughput: one sub-pixel per cycle; input stalls only when the 4-entry output queue backs up.
// Each sub-pixel does one read-modify-write of the partial-sum memory; a back-to-back hit is forwarded.
// Reset (synchronous, aresetn low) clears counters, sticky flag and output queue and restores registers.
// The partial-sum memory is not cleared: every entry is written on a bin's first sub-row before use.
module subpixel_binning_saturating_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BIN   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] simel_count
    input  logic [0:0]  s_tuser,   // [0] frame_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pixel_value
    output logic [2:0]  m_tuser,   // [0] pixel_saturated, [1] last_in_frame, [2] frame_saturated
    output logic        m_tlast    // last_in_row
);

    import sbin_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [3:0]        bin_factor_reg;
    logic [10:0]       frame_width_reg;
    logic [10:0]       frame_height_reg;
    logic [DATA_W-1:0] max_adu_reg;

    logic [CNT_W-1:0] bin_lim, width_lim, height_lim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_factor_reg   <= BIN_RESET;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            max_adu_reg      <= MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_BIN_FACTOR:   bin_factor_reg   <= cfg_wdata[3:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[10:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[10:0];
                CFG_MAX_ADU:      max_adu_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Zero behaves as one; values past the supported maximum are held at it.
    always_comb begin
        if (bin_factor_reg == '0) begin
            bin_lim = CNT_W'(1);
        end else if (CNT_W'(bin_factor_reg) > CNT_W'(MAX_BIN)) begin
            bin_lim = CNT_W'(MAX_BIN);
        end else begin
            bin_lim = CNT_W'(bin_factor_reg);
        end

        if (frame_width_reg == '0) begin
            width_lim = CNT_W'(1);
        end else if (CNT_W'(frame_width_reg) > CNT_W'(MAX_WIDTH)) begin
            width_lim = CNT_W'(MAX_WIDTH);
        end else begin
            width_lim = CNT_W'(frame_width_reg);
        end

        if (frame_height_reg == '0) begin
            height_lim = CNT_W'(1);
        end else if (CNT_W'(frame_height_reg) > CNT_W'(HEIGHT_LIMIT)) begin
            height_lim = CNT_W'(HEIGHT_LIMIT);
        end else begin
            height_lim = CNT_W'(frame_height_reg);
        end
    end

    // Request stage: raster position and memory read.
    logic             in_accept;
    logic [COL_W-1:0] in_col;
    raster_t          in_flags;

    assign in_accept = s_tvalid && s_tready;

    sbin_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_raster (
        .clk         (aclk),
        .rst_n       (aresetn),
        .accept      (in_accept),
        .frame_start (s_tuser[0]),
        .bin_lim     (bin_lim),
        .width_lim   (width_lim),
        .height_lim  (height_lim),
        .col         (in_col),
        .flags       (in_flags)
    );

    // Accumulate stage.
    logic              acc_valid_reg;
    logic [COL_W-1:0]  acc_col_reg;
    logic [DATA_W-1:0] acc_count_reg;
    raster_t           acc_flags_reg;

    logic              wr_valid_reg;
    logic [COL_W-1:0]  wr_col_reg;
    logic [DATA_W-1:0] wr_sum_reg;
    logic              sticky_reg, sticky_next;

    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] base;
    logic [DATA_W:0]   raw_sum;
    logic              sat;
    logic [DATA_W-1:0] new_sum;
    logic              sticky_now;
    logic              acc_emit;
    out_item_t         acc_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            sticky_reg    <= 1'b0;
        end else begin
            acc_valid_reg <= in_accept;
            if (acc_valid_reg) begin
                wr_valid_reg <= 1'b1;
            end
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            acc_col_reg   <= in_col;
            acc_count_reg <= s_tdata;
            acc_flags_reg <= in_flags;
        end
        if (acc_valid_reg) begin
            wr_col_reg <= acc_col_reg;
            wr_sum_reg <= new_sum;
        end
    end

    sbin_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_partial_sums (
        .clk   (aclk),
        .we    (acc_valid_reg),
        .waddr (acc_col_reg),
        .wdata (new_sum),
        .re    (in_accept),
        .raddr (in_col),
        .rdata (mem_rdata)
    );

    always_comb begin
        // The memory read was issued while the previous sub-pixel was still being written,
        // so a hit on the same column takes the value just written.
        if (acc_flags_reg.first) begin
            base = '0;
        end else if (wr_valid_reg && (wr_col_reg == acc_col_reg)) begin
            base = wr_sum_reg;
        end else begin
            base = mem_rdata;
        end

        raw_sum = {1'b0, base} + {1'b0, acc_count_reg};
        sat     = (base >= max_adu_reg) || (raw_sum >= {1'b0, max_adu_reg});
        new_sum = sat ? max_adu_reg : raw_sum[DATA_W-1:0];

        acc_emit   = acc_valid_reg && acc_flags_reg.emit;
        sticky_now = (acc_flags_reg.start ? 1'b0 : sticky_reg) || (acc_flags_reg.emit && sat);

        sticky_next = sticky_reg;
        if (acc_valid_reg) begin
            sticky_next = acc_flags_reg.frame_end ? 1'b0 : sticky_now;
        end

        acc_item.value      = new_sum;
        acc_item.sat        = sat;
        acc_item.last_row   = acc_flags_reg.last_col;
        acc_item.last_frame = acc_flags_reg.last_frame;
        acc_item.frame_sat  = sticky_now;
    end

    // Output queue.
    logic [LVL_W-1:0] fifo_level;
    out_item_t        out_item;

    sbin_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (aclk),
        .rst_n     (aresetn),
        .push      (acc_emit),
        .push_data (acc_item),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_item),
        .level     (fifo_level)
    );

    // Room must remain for the pixel in the accumulate stage and one from a new request.
    assign s_tready = ((LVL_W + 1)'(fifo_level) + (LVL_W + 1)'(acc_emit))
                      < (LVL_W + 1)'(FIFO_DEPTH);

    assign m_tdata    = out_item.value;
    assign m_tlast    = out_item.last_row;
    assign m_tuser[0] = out_item.sat;
    assign m_tuser[1] = out_item.last_frame;
    assign m_tuser[2] = out_item.frame_sat;

endmodule
